// File: src/vector_compare_select_unit_macros.svh
// Assertion macros shared by the checker files.
`ifndef VECTOR_COMPARE_SELECT_UNIT_MACROS_SVH
`define VECTOR_COMPARE_SELECT_UNIT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define VCSU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define VCSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: src/vcsu_pkg.sv
// ----------------------------------------------------------------------------
// vcsu_pkg
// Types, codes and constants shared by the vector compare and select unit.
// ----------------------------------------------------------------------------
package vcsu_pkg;

   localparam int NumRegsDefault = 32;
   localparam int NumLanes       = 8;
   localparam int RegIdxWidth    = 5;
   localparam int LaneWidth      = 3;
   localparam int DataWidth      = 16;
   localparam int QueueDepth     = 2;

   typedef enum logic [3:0] {
      ACT_VEQ      = 4'd0,
      ACT_VNE      = 4'd1,
      ACT_VABS     = 4'd2,
      ACT_VSAR     = 4'd3,
      ACT_VMOV     = 4'd4,
      ACT_LOAD     = 4'd5,
      ACT_LOAD_ACC = 4'd6,
      ACT_READ     = 4'd7,
      ACT_FLAGS    = 4'd8,
      ACT_NOP      = 4'd15
   } action_type;

   // First of the action codes that have no operation behind them.
   localparam logic [3:0] ActUnusedFirst = 4'd9;

   // Element values that pick an accumulator slice; anything else is low.
   localparam logic [3:0] AccSliceHigh = 4'd0;
   localparam logic [3:0] AccSliceMid  = 4'd1;

   localparam logic [DataWidth-1:0] SignMin = 16'h8000;
   localparam logic [DataWidth-1:0] SignMax = 16'h7FFF;

   typedef struct packed {
      logic [3:0]           action;
      logic [RegIdxWidth-1:0] dest_reg;
      logic [RegIdxWidth-1:0] src_reg;
      logic [RegIdxWidth-1:0] alt_reg;
      logic [3:0]           element;
      logic [LaneWidth-1:0] lane;
      logic [DataWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] read_value;
      logic [7:0]           compare_mask;
   } rsp_type;

   // Decoded item held in the queue between front and back.
   typedef struct packed {
      action_type           op;
      logic [RegIdxWidth-1:0] dest_reg;
      logic [RegIdxWidth-1:0] src_reg;
      logic [RegIdxWidth-1:0] alt_reg;
      logic [3:0]           element;
      logic [LaneWidth-1:0] lane;
      logic [DataWidth-1:0] value;
   } uop_type;

   // Source lane for the broadcast of the second operand.
   function automatic logic [LaneWidth-1:0] bcast_lane(input logic [3:0] e,
                                                       input logic [LaneWidth-1:0] i);
      logic [LaneWidth-1:0] s;
      if (e < 4'd2) s = i;
      else if (e < 4'd4) s = {i[2:1], e[0]};
      else if (e < 4'd8) s = {i[2], e[1:0]};
      else s = e[2:0];
      return s;
   endfunction

endpackage

// File: src/vcsu_if.sv
// ----------------------------------------------------------------------------
// vcsu_if
// Valid and ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface vcsu_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: src/vcsu_front.sv
// ----------------------------------------------------------------------------
// vcsu_front
// Accepts request words, decodes the action and queues the item.
// ----------------------------------------------------------------------------
module vcsu_front (
   input  logic                clock,
   input  logic                reset,
   vcsu_if.sink                req,
   output vcsu_pkg::uop_type   uop,
   output logic                uop_valid,
   input  logic                uop_take
);
   localparam int Depth = vcsu_pkg::QueueDepth;

   vcsu_pkg::uop_type q_ff [Depth];
   logic [$clog2(Depth)-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [$clog2(Depth):0]   cnt_ff, cnt_in;
   vcsu_pkg::uop_type        dec;
   logic                     push;

   always_comb begin
      dec.dest_reg = req.data.dest_reg;
      dec.src_reg  = req.data.src_reg;
      dec.alt_reg  = req.data.alt_reg;
      dec.element  = req.data.element;
      dec.lane     = req.data.lane;
      dec.value    = req.data.value;
      unique case (req.data.action)
         vcsu_pkg::ACT_VEQ:      dec.op = vcsu_pkg::ACT_VEQ;
         vcsu_pkg::ACT_VNE:      dec.op = vcsu_pkg::ACT_VNE;
         vcsu_pkg::ACT_VABS:     dec.op = vcsu_pkg::ACT_VABS;
         vcsu_pkg::ACT_VSAR:     dec.op = vcsu_pkg::ACT_VSAR;
         vcsu_pkg::ACT_VMOV:     dec.op = vcsu_pkg::ACT_VMOV;
         vcsu_pkg::ACT_LOAD:     dec.op = vcsu_pkg::ACT_LOAD;
         vcsu_pkg::ACT_LOAD_ACC: dec.op = vcsu_pkg::ACT_LOAD_ACC;
         vcsu_pkg::ACT_READ:     dec.op = vcsu_pkg::ACT_READ;
         vcsu_pkg::ACT_FLAGS:    dec.op = vcsu_pkg::ACT_FLAGS;
         default: dec.op = vcsu_pkg::ACT_NOP;
      endcase
   end

   assign req.ready = (cnt_ff != Depth[$clog2(Depth):0]);
   assign push      = req.valid && req.ready;
   assign uop_valid = (cnt_ff != '0);
   assign uop       = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = uop_take ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{$clog2(Depth){1'b0}}, push}
             - {{$clog2(Depth){1'b0}}, uop_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
   end
endmodule

// File: src/vcsu_back.sv
// ----------------------------------------------------------------------------
// vcsu_back
// Executes queued items on the register file, accumulator and flags.
// ----------------------------------------------------------------------------
module vcsu_back #(
   parameter int NUM_REGS = vcsu_pkg::NumRegsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  vcsu_pkg::uop_type  uop,
   input  logic               uop_valid,
   output logic               uop_take,
   vcsu_if.source             rsp
);
   localparam int L  = vcsu_pkg::NumLanes;
   localparam int W  = vcsu_pkg::DataWidth;
   localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   // Register index wrap, worked out once for all 32 possible indexes.
   function automatic logic [32*RW-1:0] wrap_table();
      logic [32*RW-1:0] t;
      for (int k = 0; k < 32; k++) begin
         t[k*RW +: RW] = RW'(k % NUM_REGS);
      end
      return t;
   endfunction

   localparam logic [32*RW-1:0] WrapTab = wrap_table();

   // Register file: one word per lane, held as flip-flops with a valid bit per
   // register so that unwritten registers read as zero after reset.
   logic [L-1:0][W-1:0] vf_ff [NUM_REGS];
   logic [NUM_REGS-1:0] vvld_ff;
   logic [L-1:0][W-1:0] acch_ff, accm_ff, accl_ff;
   logic [7:0]          cmpl_ff, cmph_ff, carh_ff, carl_ff;
   logic                ovld_ff, ovld_in;
   vcsu_pkg::rsp_type   out_ff;

   logic [RW-1:0] di, si, ai;
   logic [L-1:0][W-1:0] vs, vt_raw, vte, res, accres, slice, vd, one_vec;
   logic [7:0] mask;
   logic       wr_all, wr_one, wr_acc;
   logic [W-1:0] one_val;

   function automatic logic [RW-1:0] wrap(input logic [4:0] r);
      return WrapTab[r*RW +: RW];
   endfunction

   assign di = wrap(uop.dest_reg);
   assign si = wrap(uop.src_reg);
   assign ai = wrap(uop.alt_reg);

   assign uop_take  = uop_valid && (!ovld_ff || rsp.ready);
   assign rsp.valid = ovld_ff;
   assign rsp.data  = out_ff;
   assign ovld_in   = uop_take ? 1'b1 : (rsp.ready ? 1'b0 : ovld_ff);

   always_comb begin
      vs     = vvld_ff[si] ? vf_ff[si] : '0;
      vt_raw = vvld_ff[ai] ? vf_ff[ai] : '0;
      vd     = vvld_ff[di] ? vf_ff[di] : '0;
      for (int i = 0; i < L; i++) begin
         vte[i] = vt_raw[vcsu_pkg::bcast_lane(uop.element, 3'(i))];
      end
      unique case (uop.element)
         vcsu_pkg::AccSliceHigh: slice = acch_ff;
         vcsu_pkg::AccSliceMid:  slice = accm_ff;
         default: slice = accl_ff;
      endcase
      mask   = '0;
      res    = '0;
      accres = '0;
      for (int i = 0; i < L; i++) begin
         logic set;
         logic [W-1:0] neg;
         neg = W'(0) - vte[i];
         set = (uop.op == vcsu_pkg::ACT_VEQ) ? (!carh_ff[i] && vs[i] == vte[i])
                                             : (carh_ff[i] || vs[i] != vte[i]);
         if (uop.op == vcsu_pkg::ACT_VABS) begin
            if (vs[i][W-1]) begin
               accres[i] = neg;
               res[i]    = (vte[i] == vcsu_pkg::SignMin) ? vcsu_pkg::SignMax : neg;
            end else if (vs[i] == '0) begin
               accres[i] = '0;
               res[i]    = '0;
            end else begin
               accres[i] = vte[i];
               res[i]    = vte[i];
            end
         end else if (uop.op == vcsu_pkg::ACT_VSAR) begin
            res[i] = slice[i];
         end else begin
            mask[i]   = set;
            res[i]    = set ? vs[i] : vte[i];
            accres[i] = res[i];
         end
      end
      wr_all = (uop.op == vcsu_pkg::ACT_VEQ) || (uop.op == vcsu_pkg::ACT_VNE)
            || (uop.op == vcsu_pkg::ACT_VABS) || (uop.op == vcsu_pkg::ACT_VSAR);
      wr_acc = (uop.op == vcsu_pkg::ACT_VEQ) || (uop.op == vcsu_pkg::ACT_VNE)
            || (uop.op == vcsu_pkg::ACT_VABS);
      wr_one = (uop.op == vcsu_pkg::ACT_VMOV) || (uop.op == vcsu_pkg::ACT_LOAD);
      one_val = (uop.op == vcsu_pkg::ACT_VMOV) ? vt_raw[uop.element[2:0]] : uop.value;
      // A single-lane write keeps the other lanes, which read as zero if the
      // register has never been written.
      one_vec = vd;
      one_vec[uop.lane] = one_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vvld_ff <= '0;
         acch_ff <= '0;
         accm_ff <= '0;
         accl_ff <= '0;
         cmpl_ff <= '0;
         cmph_ff <= '0;
         carh_ff <= '0;
         carl_ff <= '0;
         ovld_ff <= 1'b0;
      end else begin
         ovld_ff <= ovld_in;
         if (uop_take) begin
            if (wr_all || wr_one) vvld_ff[di] <= 1'b1;
            if (wr_acc) accl_ff <= accres;
            case (uop.op)
               vcsu_pkg::ACT_VEQ, vcsu_pkg::ACT_VNE: begin
                  cmpl_ff <= mask;
                  cmph_ff <= '0;
                  carh_ff <= '0;
                  carl_ff <= '0;
               end
               vcsu_pkg::ACT_LOAD_ACC: begin
                  unique case (uop.element)
                     vcsu_pkg::AccSliceHigh: acch_ff[uop.lane] <= uop.value;
                     vcsu_pkg::AccSliceMid:  accm_ff[uop.lane] <= uop.value;
                     default: accl_ff[uop.lane] <= uop.value;
                  endcase
               end
               vcsu_pkg::ACT_FLAGS: begin
                  cmpl_ff <= uop.value[7:0];
                  carh_ff <= uop.value[15:8];
               end
               default: ;
            endcase
         end
      end
   end

   // Register file words and the output payload need no reset.
   always_ff @(posedge clock) begin
      if (uop_take) begin
         if (wr_all) begin
            vf_ff[di] <= res;
         end else if (wr_one) begin
            vf_ff[di] <= one_vec;
         end
         out_ff.read_value <= (uop.op == vcsu_pkg::ACT_READ) ? vs[uop.lane] : '0;
         unique case (uop.op)
            vcsu_pkg::ACT_VEQ, vcsu_pkg::ACT_VNE: out_ff.compare_mask <= mask;
            vcsu_pkg::ACT_FLAGS: out_ff.compare_mask <= uop.value[7:0];
            default: out_ff.compare_mask <= cmpl_ff;
         endcase
      end
   end

   // Unused in behaviour but kept as architectural state.
   logic unused_flags;
   assign unused_flags = ^{cmph_ff, carl_ff};
endmodule

// File: src/vector_compare_select_unit.sv
// ----------------------------------------------------------------------------
// vector_compare_select_unit
// Eight-lane sixteen-bit vector unit for compare, select and move operations.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word
//  req_    | in        | action, registers, element, lane, value
//  rsp_    | out       | read_value, compare_mask
//
// Each word passes once through the execute stage, so a word can be accepted
// every cycle unless responses stall; it passes the queue and output register.
// The rate is set by the single execute stage reading the register file.
// Reset is synchronous and active high; it clears the queue, flags,
// accumulator and register valid bits, so the unit is ready at once.
// A stalled response holds the execute stage; the two-entry queue in front
// absorbs requests until it fills.
module vector_compare_select_unit #(
   parameter int NUM_REGS = vcsu_pkg::NumRegsDefault
) (
   input  logic        clock,
   input  logic        reset,
   vcsu_if.sink        req_ch,
   vcsu_if.source      rsp_ch
);
   vcsu_pkg::uop_type uop;
   logic              uop_valid;
   logic              uop_take;

   // The front decodes each word and holds it in a short queue.
   vcsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .uop       (uop),
      .uop_valid (uop_valid),
      .uop_take  (uop_take)
   );

   // The back reads operands, computes all lanes and updates state.
   vcsu_back #(.NUM_REGS(NUM_REGS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .uop       (uop),
      .uop_valid (uop_valid),
      .uop_take  (uop_take),
      .rsp       (rsp_ch)
   );
endmodule

// File: src/vcsu_checker.sv
// ----------------------------------------------------------------------------
// vcsu_checker
// Port-level checks on the vector compare and select unit.
// ----------------------------------------------------------------------------
`include "vector_compare_select_unit_macros.svh"
module vcsu_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input vcsu_pkg::rsp_type rsp_data
);
   `VCSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "stalled response changed")
   // A word taken while the output is empty must respond after the queue and output register.
   `VCSU_ASSERT_IMP(a_rsp_follows, clock, reset, req_valid && req_ready && !rsp_valid,
      ##2 rsp_valid, "accepted word gave no response")
   `VCSU_ASSERT_IMP(a_ready_after_reset, clock, reset, $fell(reset), req_ready,
      "not ready after reset")
endmodule

bind vector_compare_select_unit vcsu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
